/* rtl/ifd_pkg.sv */
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the frame deframer: register indexes, reset
// values, field widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ifd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PayloadLenW = 6;
  localparam int unsigned ByteIndexW  = 5;
  localparam int unsigned CfgIndexW   = 2;

  localparam logic [CfgIndexW-1:0] CfgStartOne    = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgStartReport = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgStartAck    = 2'd2;

  localparam logic [ByteW-1:0] StartOneRst    = 8'h55;
  localparam logic [ByteW-1:0] StartReportRst = 8'h55;
  localparam logic [ByteW-1:0] StartAckRst    = 8'hAF;

  typedef enum logic [7:0] {
    StHunt  = 8'b0000_0001,
    StHdr2  = 8'b0000_0010,
    StId    = 8'b0000_0100,
    StLen   = 8'b0000_1000,
    StData  = 8'b0001_0000,
    StSum   = 8'b0010_0000,
    StRead  = 8'b0100_0000,
    StLoad  = 8'b1000_0000
  } ifd_state_e;

  typedef struct packed {
    logic sum_init;
    logic sum_add;
    logic set_kind;
    logic set_id;
    logic set_len;
    logic store_byte;
    logic burst_start;
    logic rd_en;
    logic load_out;
    logic burst_next;
  } ifd_cmd_t;

  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic len_ok;
    logic len_zero;
    logic data_done;
    logic sum_ok;
    logic burst_last;
    logic out_free;
  } ifd_status_t;

endpackage

/* rtl/ifd_ram.sv */
// ----------------------------------------------------------------------------
// ifd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ifd_ctrl.sv */
// ----------------------------------------------------------------------------
// ifd_ctrl
// Frame parse and burst replay sequencer. Issues commands to the datapath
// from the accepted word and the datapath status.
// ----------------------------------------------------------------------------
module ifd_ctrl
  import ifd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ifd_status_t status_i,
  output ifd_cmd_t    cmd_o
);

  ifd_state_e state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q == StRead) || (state_q == StLoad);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StHunt: begin
        if (accept) begin
          cmd_o.sum_init = 1'b1;
          if (status_i.hdr1_match) state_d = StHdr2;
        end
      end
      StHdr2: begin
        if (accept) begin
          cmd_o.sum_add = 1'b1;
          if (status_i.hdr2_match) begin
            cmd_o.set_kind = 1'b1;
            state_d        = StId;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StId: begin
        if (accept) begin
          cmd_o.sum_add = 1'b1;
          cmd_o.set_id  = 1'b1;
          state_d       = StLen;
        end
      end
      StLen: begin
        if (accept) begin
          if (status_i.len_ok) begin
            cmd_o.sum_add = 1'b1;
            cmd_o.set_len = 1'b1;
            state_d       = status_i.len_zero ? StSum : StData;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StData: begin
        if (accept) begin
          cmd_o.sum_add    = 1'b1;
          cmd_o.store_byte = 1'b1;
          if (status_i.data_done) state_d = StSum;
        end
      end
      StSum: begin
        if (accept) begin
          if (status_i.sum_ok) begin
            cmd_o.burst_start = 1'b1;
            state_d           = StRead;
          end else begin
            state_d = StHunt;
          end
        end
      end
      StRead: begin
        cmd_o.rd_en = 1'b1;
        state_d     = StLoad;
      end
      StLoad: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (status_i.burst_last) begin
            state_d = StHunt;
          end else begin
            cmd_o.burst_next = 1'b1;
            state_d          = StRead;
          end
        end
      end
      default: state_d = StHunt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StHunt;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ifd_datapath.sv */
// ----------------------------------------------------------------------------
// ifd_datapath
// Header registers, running checksum, frame fields, payload buffer and the
// output word register.
// ----------------------------------------------------------------------------
module ifd_datapath
  import ifd_pkg::*;
#(
  parameter int unsigned MaxPayload = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIndexW-1:0]   cfg_index_i,
  input  logic [ByteW-1:0]       cfg_wdata_i,
  input  logic [ByteW-1:0]       rx_byte_i,
  input  ifd_cmd_t               cmd_i,
  output ifd_status_t            status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ByteW-1:0]       msg_id_o,
  output logic                   is_ack_o,
  output logic [PayloadLenW-1:0] payload_len_o,
  output logic [ByteIndexW-1:0]  byte_index_o,
  output logic [ByteW-1:0]       payload_byte_o,
  output logic                   payload_valid_o,
  output logic                   last_o
);

  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned LenW  = $clog2(MaxPayload + 1);
  localparam int unsigned CmpW  = LenW + 1;
  localparam logic [ByteW-1:0] MaxLen = ByteW'(MaxPayload);

  logic [ByteW-1:0] start_one_q, start_report_q, start_ack_q;
  logic [ByteW-1:0] sum_q;
  logic [ByteW-1:0] frame_id_q;
  logic             frame_ack_q;
  logic [LenW-1:0]  len_q;
  logic [AddrW-1:0] fill_q;
  logic [AddrW-1:0] k_q;
  logic [ByteW-1:0] rdata;
  logic             hdr2_report, hdr2_ack, len_zero_q;

  logic                   out_valid_q;
  logic [ByteW-1:0]       out_id_q;
  logic                   out_ack_q;
  logic [PayloadLenW-1:0] out_len_q;
  logic [ByteIndexW-1:0]  out_idx_q;
  logic [ByteW-1:0]       out_byte_q;
  logic                   out_pvalid_q;
  logic                   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_one_q    <= StartOneRst;
      start_report_q <= StartReportRst;
      start_ack_q    <= StartAckRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgStartOne:    start_one_q    <= cfg_wdata_i;
        CfgStartReport: start_report_q <= cfg_wdata_i;
        CfgStartAck:    start_ack_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign hdr2_report = (rx_byte_i == start_report_q);
  assign hdr2_ack    = (rx_byte_i == start_ack_q);
  assign len_zero_q  = (len_q == '0);

  assign status_o.hdr1_match = (rx_byte_i == start_one_q);
  assign status_o.hdr2_match = hdr2_report || hdr2_ack;
  assign status_o.len_ok     = (rx_byte_i <= MaxLen);
  assign status_o.len_zero   = (rx_byte_i == '0);
  assign status_o.data_done  = (CmpW'(fill_q) + CmpW'(1)) >= CmpW'(len_q);
  assign status_o.sum_ok     = (sum_q == rx_byte_i);
  assign status_o.burst_last = len_zero_q || ((CmpW'(k_q) + CmpW'(1)) == CmpW'(len_q));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      frame_id_q  <= '0;
      frame_ack_q <= 1'b0;
      len_q       <= '0;
      fill_q      <= '0;
      k_q         <= '0;
    end else begin
      if (cmd_i.sum_init) sum_q <= rx_byte_i;
      else if (cmd_i.sum_add) sum_q <= sum_q + rx_byte_i;
      if (cmd_i.set_kind) frame_ack_q <= !hdr2_report;
      if (cmd_i.set_id) frame_id_q <= rx_byte_i;
      if (cmd_i.set_len) begin
        len_q  <= LenW'(rx_byte_i);
        fill_q <= '0;
      end else if (cmd_i.store_byte) begin
        fill_q <= fill_q + AddrW'(1);
      end
      if (cmd_i.burst_start) k_q <= '0;
      else if (cmd_i.burst_next) k_q <= k_q + AddrW'(1);
    end
  end

  ifd_ram #(
    .Width (ByteW),
    .Depth (MaxPayload)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_byte),
    .waddr_i (fill_q),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (k_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_id_q     <= frame_id_q;
      out_ack_q    <= frame_ack_q;
      out_len_q    <= PayloadLenW'(len_q);
      out_idx_q    <= ByteIndexW'(k_q);
      out_byte_q   <= len_zero_q ? '0 : rdata;
      out_pvalid_q <= !len_zero_q;
      out_last_q   <= status_o.burst_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign msg_id_o        = out_id_q;
  assign is_ack_o        = out_ack_q;
  assign payload_len_o   = out_len_q;
  assign byte_index_o    = out_idx_q;
  assign payload_byte_o  = out_byte_q;
  assign payload_valid_o = out_pvalid_q;
  assign last_o          = out_last_q;

endmodule

/* rtl/imu_frame_deframer.sv */
// After a frame's checksum word, its first result word is read from the buffer
// (StRead), then loaded into the output register (StLoad) once that is free.
// Throughput: one input word per cycle while parsing; replay reads each word
// from the buffer, then loads it, and input is stalled during replay.
// Reset: asynchronous, active low; parser hunts for header 1, registers take
// their default header values. The payload buffer is not cleared.
// ----------------------------------------------------------------------------
// imu_frame_deframer
// Byte-serial frame parser with checksum check and buffered payload replay.
// ----------------------------------------------------------------------------
module imu_frame_deframer
  import ifd_pkg::*;
#(
  parameter int unsigned MaxPayload = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIndexW-1:0]   cfg_index_i,
  input  logic [ByteW-1:0]       cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [ByteW-1:0]       rx_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ByteW-1:0]       msg_id_o,
  output logic                   is_ack_o,
  output logic [PayloadLenW-1:0] payload_len_o,
  output logic [ByteIndexW-1:0]  byte_index_o,
  output logic [ByteW-1:0]       payload_byte_o,
  output logic                   payload_valid_o,
  output logic                   last_o
);

  ifd_cmd_t    cmd;
  ifd_status_t status;

  ifd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ifd_datapath #(
    .MaxPayload (MaxPayload)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .msg_id_o        (msg_id_o),
    .is_ack_o        (is_ack_o),
    .payload_len_o   (payload_len_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/ifd_checker.sv */
// ----------------------------------------------------------------------------
// ifd_checker
// Port-level checks on the deframer result words, bound to the top level.
// ----------------------------------------------------------------------------
module ifd_checker
  import ifd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [PayloadLenW-1:0] payload_len_o,
  input logic [ByteIndexW-1:0]  byte_index_o,
  input logic [ByteW-1:0]       payload_byte_o,
  input logic                   payload_valid_o,
  input logic                   last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_index_o)
      && $stable(payload_byte_o) && $stable(last_o))
    else $error("stalled result word changed");

  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> last_o && payload_byte_o == '0
      && byte_index_o == '0 && payload_len_o == '0)
    else $error("empty frame word malformed");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && payload_valid_o
      |-> PayloadLenW'(byte_index_o) + PayloadLenW'(1) == payload_len_o)
    else $error("last word index does not match length");

  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken in the middle of a burst");

endmodule

bind imu_frame_deframer ifd_checker u_ifd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .payload_len_o   (payload_len_o),
  .byte_index_o    (byte_index_o),
  .payload_byte_o  (payload_byte_o),
  .payload_valid_o (payload_valid_o),
  .last_o          (last_o)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame deframer. Byte streams are built from
// well-formed frames with random content, broken frames and line noise, and
// fed through the valid/stall input while the result side stalls at random
// in phases 0 to 4. A bit-accurate parser model predicts every result word;
// each accepted word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import ifd_pkg::*;

  localparam int MaxPayload   = 32;
  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 8;
  localparam int NumPhases    = 7;
  localparam logic [CfgIndexW-1:0] CfgUnmapped = 2'd3;

  typedef enum int {
    FrameGood,
    FrameBadSum,
    FrameBadHdr2,
    FrameLongLen,
    FrameEchoHdr1
  } frame_flaw_e;

  typedef struct packed {
    logic [ByteW-1:0]       msg_id;
    logic                   is_ack;
    logic [PayloadLenW-1:0] payload_len;
    logic [ByteIndexW-1:0]  byte_index;
    logic [ByteW-1:0]       payload_byte;
    logic                   payload_valid;
    logic                   last;
  } frame_word_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0]   cfg_index_i = '0;
  logic [ByteW-1:0]       cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic [ByteW-1:0]       rx_byte_i   = '0;
  logic                   out_stall_i = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [ByteW-1:0]       msg_id_o;
  logic                   is_ack_o;
  logic [PayloadLenW-1:0] payload_len_o;
  logic [ByteIndexW-1:0]  byte_index_o;
  logic [ByteW-1:0]       payload_byte_o;
  logic                   payload_valid_o;
  logic                   last_o;

  // register copies shared by the frame builder and the parser model
  logic [ByteW-1:0] hdr_one    = StartOneRst;
  logic [ByteW-1:0] hdr_report = StartReportRst;
  logic [ByteW-1:0] hdr_ack    = StartAckRst;

  ifd_state_e             pm_state;
  logic [ByteW-1:0]       pm_sum;
  logic [PayloadLenW-1:0] pm_fill;
  logic [PayloadLenW-1:0] pm_len;
  logic [ByteW-1:0]       pm_id;
  logic                   pm_ack;
  logic [ByteW-1:0]       pm_payload [MaxPayload];

  logic [ByteW-1:0] rx_bytes_q [$];
  frame_word_t      frame_words_q [$];
  frame_word_t      seen_word;
  frame_word_t      want_word;
  int               bytes_pushed   = 0;
  int               err_count      = 0;
  int               cycle_count    = 0;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;

  imu_frame_deframer #(
    .MaxPayload(MaxPayload)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .msg_id_o       (msg_id_o),
    .is_ack_o       (is_ack_o),
    .payload_len_o  (payload_len_o),
    .byte_index_o   (byte_index_o),
    .payload_byte_o (payload_byte_o),
    .payload_valid_o(payload_valid_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic replay_frame();
    frame_word_t w;
    int          k;
    if (pm_len == 0) begin
      w = '{msg_id: pm_id, is_ack: pm_ack, payload_len: '0, byte_index: '0,
            payload_byte: '0, payload_valid: 1'b0, last: 1'b1};
      frame_words_q.push_back(w);
    end else begin
      for (k = 0; k < int'(pm_len); k++) begin
        w = '{msg_id: pm_id, is_ack: pm_ack, payload_len: pm_len,
              byte_index: ByteIndexW'(k), payload_byte: pm_payload[ByteIndexW'(k)],
              payload_valid: 1'b1, last: (k == int'(pm_len) - 1)};
        frame_words_q.push_back(w);
      end
    end
  endtask

  task automatic deframe_byte(input logic [ByteW-1:0] b);
    case (pm_state)
      StHunt: begin
        if (b == hdr_one) pm_state = StHdr2;
        pm_sum = b;
      end
      StHdr2: begin
        if (b == hdr_report || b == hdr_ack) begin
          pm_ack   = (b != hdr_report);
          pm_state = StId;
        end else begin
          pm_state = StHunt;
        end
        pm_sum = pm_sum + b;
      end
      StId: begin
        pm_id    = b;
        pm_sum   = pm_sum + b;
        pm_state = StLen;
      end
      StLen: begin
        if (int'(b) <= MaxPayload) begin
          pm_len   = PayloadLenW'(b);
          pm_fill  = '0;
          pm_sum   = pm_sum + b;
          pm_state = (b != 0) ? StData : StSum;
        end else begin
          pm_state = StHunt;
        end
      end
      StData: begin
        pm_payload[pm_fill[ByteIndexW-1:0]] = b;
        pm_fill  = pm_fill + 1'b1;
        pm_sum   = pm_sum + b;
        if (pm_fill >= pm_len) pm_state = StSum;
      end
      StSum: begin
        pm_state = StHunt;
        if (pm_sum == b) replay_frame();
      end
      default: begin
        pm_state = StHunt;
      end
    endcase
  endtask

  // driver: model each accepted word, then offer the next one unless stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      pm_state    = StHunt;
      pm_sum      = '0;
      pm_fill     = '0;
      pm_len      = '0;
      pm_id       = '0;
      pm_ack      = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (rx_bytes_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_byte_i  <= rx_bytes_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic string word_str(input frame_word_t w);
    return $sformatf("id=%02h ack=%0d len=%0d idx=%0d byte=%02h pv=%0d last=%0d",
                     w.msg_id, w.is_ack, w.payload_len, w.byte_index,
                     w.payload_byte, w.payload_valid, w.last);
  endfunction

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen_word = {msg_id_o, is_ack_o, payload_len_o, byte_index_o,
                     payload_byte_o, payload_valid_o, last_o};
        if (frame_words_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected word: %s", word_str(seen_word));
        end else begin
          want_word = frame_words_q.pop_front();
          if (seen_word !== want_word) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected %s, got %s", word_str(want_word),
                       word_str(seen_word));
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic put_byte(input logic [ByteW-1:0] b);
    rx_bytes_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_frame(input bit ack, input logic [ByteW-1:0] id, input int len,
                            input frame_flaw_e flaw, input int fill);
    logic [ByteW-1:0] hdr2;
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int               k;
    if (flaw == FrameEchoHdr1) put_byte(hdr_one);
    put_byte(hdr_one);
    if (flaw == FrameBadHdr2) begin
      do hdr2 = ByteW'($urandom_range(0, 255));
      while (hdr2 == hdr_report || hdr2 == hdr_ack);
      put_byte(hdr2);
      return;
    end
    hdr2 = ack ? hdr_ack : hdr_report;
    put_byte(hdr2);
    put_byte(id);
    sum = hdr_one + hdr2 + id;
    if (flaw == FrameLongLen) begin
      put_byte(len > MaxPayload ? ByteW'(len) : ByteW'($urandom_range(MaxPayload + 1, 255)));
      return;
    end
    put_byte(ByteW'(len));
    sum = sum + ByteW'(len);
    for (k = 0; k < len; k++) begin
      b = (fill < 0) ? ByteW'($urandom_range(0, 255)) : ByteW'(fill);
      put_byte(b);
      sum = sum + b;
    end
    if (flaw == FrameBadSum) sum = sum + ByteW'($urandom_range(1, 255));
    put_byte(sum);
  endtask

  task automatic push_random(input int target);
    int start;
    int r;
    int len;
    bit ack;
    logic [ByteW-1:0] id;
    start = bytes_pushed;
    while (bytes_pushed - start < target) begin
      r = $urandom_range(0, 11);
      if (r == 0) len = MaxPayload;
      else if (r == 1) len = $urandom_range(9, MaxPayload - 1);
      else len = $urandom_range(0, 8);
      ack = 1'($urandom_range(0, 1));
      id  = ByteW'($urandom_range(0, 255));
      r   = $urandom_range(0, 99);
      if (r < 70) push_frame(ack, id, len, FrameGood, -1);
      else if (r < 78) push_frame(ack, id, len, FrameBadSum, -1);
      else if (r < 84) push_frame(ack, id, len, FrameBadHdr2, -1);
      else if (r < 89) push_frame(ack, id, 0, FrameLongLen, -1);
      else if (r < 93) push_frame(ack, id, len, FrameEchoHdr1, -1);
      else begin
        repeat ($urandom_range(1, 4))
          put_byte(($urandom_range(0, 3) == 0) ? hdr_one : ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [ByteW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgStartOne:    hdr_one    = val;
      CfgStartReport: hdr_report = val;
      CfgStartAck:    hdr_ack    = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (rx_bytes_q.size() > 0 || in_valid_i || frame_words_q.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [ByteW-1:0] one_tab    [NumPhases];
    logic [ByteW-1:0] report_tab [NumPhases];
    logic [ByteW-1:0] ack_tab    [NumPhases];
    int ph;
    one_tab    = '{8'h55, 8'h00, 8'hFF, 8'h55, 8'hA5, 8'h00, 8'h7F};
    report_tab = '{8'h55, 8'hFF, 8'h00, 8'h55, 8'h5A, 8'h00, 8'h80};
    ack_tab    = '{8'hAF, 8'h80, 8'h00, 8'hAF, 8'hC3, 8'h00, 8'h01};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_idle();
        if (ph == 5) begin
          one_tab[ph]    = ByteW'($urandom_range(0, 255));
          report_tab[ph] = ByteW'($urandom_range(0, 255));
          ack_tab[ph]    = ByteW'($urandom_range(0, 255));
        end
        write_reg(CfgStartOne, one_tab[ph]);
        write_reg(CfgStartReport, report_tab[ph]);
        write_reg(CfgStartAck, ack_tab[ph]);
        if (ph == 3) write_reg(CfgUnmapped, 8'h00);
        @(posedge clk_i);
        cfg_we_i <= 1'b0;
      end
      @(negedge clk_i);
      send_idle_pct  = (ph < 3) ? 35 : (ph < 5) ? 68 : 0;
      recv_stall_pct = (ph < 3) ? 68 : (ph < 5) ? 35 : 0;
      if (ph == 0) begin
        push_frame(1'b0, 8'h00, 0, FrameGood, 0);
        push_frame(1'b1, 8'hFF, 1, FrameGood, 255);
        push_frame(1'b0, 8'h3C, 1, FrameBadSum, 0);
        push_frame(1'b0, 8'h01, MaxPayload + 1, FrameLongLen, 0);
        push_frame(1'b0, 8'h00, 0, FrameBadHdr2, 0);
      end else begin
        if (ph == 1) push_frame(1'b1, 8'h80, MaxPayload, FrameGood, -1);
        push_random(80);
      end
    end
    wait_idle();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
